// ----- src/aprr_pkg.sv -----
// types, constants and saturating fixed-point helpers for the reaction rate block
// signed Q8.24 values travel together with a sticky saturation flag
// no dependencies
package aprr_pkg;

    localparam int FRAC_BITS = 24;
    localparam int FX_W      = 32;

    // -1.0 in Q8.24
    localparam logic signed [63:0] FX_NEG_ONE = -(64'sd1 <<< FRAC_BITS);
    localparam logic signed [63:0] FX_HALF    = 64'sd1 <<< (FRAC_BITS - 1);

    // register indexes of the configuration port
    localparam logic [2:0] REG_GAIN_K     = 3'd0;
    localparam logic [2:0] REG_THRESH_A   = 3'd1;
    localparam logic [2:0] REG_MU1        = 3'd2;
    localparam logic [2:0] REG_MU2        = 3'd3;
    localparam logic [2:0] REG_EPS        = 3'd4;

    // value with its saturation flag
    typedef struct packed {
        logic                    flag;
        logic signed [FX_W-1:0]  val;
    } fx_t;

    // clamp a wide value to a signed range of sw bits
    function automatic fx_t fx_sat(input logic signed [63:0] x, input int sw);
        logic signed [63:0] hi;
        logic signed [63:0] lo;
        fx_t                r;
        hi = (64'sd1 <<< (sw - 1)) - 64'sd1;
        lo = -hi - 64'sd1;
        if (x > hi)
        begin
            r.flag = 1'b1;
            r.val  = hi[FX_W-1:0];
        end
        else if (x < lo)
        begin
            r.flag = 1'b1;
            r.val  = lo[FX_W-1:0];
        end
        else
        begin
            r.flag = 1'b0;
            r.val  = x[FX_W-1:0];
        end
        return r;
    endfunction

    // saturating sum, flags merge
    function automatic fx_t fx_add(input fx_t a, input fx_t b, input int sw);
        logic signed [63:0] s;
        fx_t                r;
        s = 64'(a.val) + 64'(b.val);
        r = fx_sat(s, sw);
        r.flag = r.flag | a.flag | b.flag;
        return r;
    endfunction

    // saturating negation
    function automatic fx_t fx_neg(input fx_t a, input int sw);
        logic signed [63:0] s;
        fx_t                r;
        s = -64'(a.val);
        r = fx_sat(s, sw);
        r.flag = r.flag | a.flag;
        return r;
    endfunction

    // plain input value, no flag
    function automatic fx_t fx_raw(input logic signed [FX_W-1:0] x);
        fx_t r;
        r.flag = 1'b0;
        r.val  = x;
        return r;
    endfunction

endpackage

// ----- src/aprr_delay.sv -----
// enable-gated delay line for payload that must wait for a slower branch
// depends on nothing
module aprr_delay #(
    parameter int W = 33,
    parameter int N = 1
) (
    input  logic         clk,
    input  logic         en,
    input  logic [W-1:0] din,
    output logic [W-1:0] dout
);

    logic [W-1:0] line_reg [0:N-1];

    // shift when the pipeline advances
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            line_reg[0] <= din;
            for (int i = 1; i < N; i++)
            begin
                line_reg[i] <= line_reg[i-1];
            end
        end
    end

    assign dout = line_reg[N-1];

endmodule

// ----- src/aprr_fmul.sv -----
// two-stage Q8.24 multiplier: registered product, then round half up and saturate
// depends on aprr_pkg
module aprr_fmul
    import aprr_pkg::*;
#(
    parameter int SAT_W = 32
) (
    input  logic clk,
    input  logic en,
    input  fx_t  a,
    input  fx_t  b,
    output fx_t  y
);

    logic signed [63:0] prod_reg;
    logic               flag_reg;
    fx_t                y_reg;
    fx_t                y_next;
    logic signed [63:0] rnd;

    // round and clamp the product
    always_comb
    begin
        rnd    = (prod_reg + FX_HALF) >>> FRAC_BITS;
        y_next = fx_sat(rnd, SAT_W);
        y_next.flag = y_next.flag | flag_reg;
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            prod_reg <= 64'(a.val) * 64'(b.val);
            flag_reg <= a.flag | b.flag;
            y_reg    <= y_next;
        end
    end

    assign y = y_reg;

endmodule

// ----- src/aprr_div.sv -----
// pipelined restoring divider for (n * 2^24) / d, one quotient bit a stage
// depends on aprr_pkg; 2 + 32 + FRAC_BITS stages: setup, one per quotient bit, output
module aprr_div
    import aprr_pkg::*;
#(
    parameter int SAT_W = 32
) (
    input  logic clk,
    input  logic en,
    input  fx_t  num,
    input  fx_t  den,
    output fx_t  quo
);

    localparam int QB = FX_W + FRAC_BITS;

    logic [FX_W-1:0] rem_reg  [0:QB];
    logic [QB-1:0]   nq_reg   [0:QB];
    logic [FX_W-1:0] dabs_reg [0:QB];
    logic            neg_reg  [0:QB];
    logic            zero_reg [0:QB];
    logic            pos_reg  [0:QB];
    logic            flag_reg [0:QB];
    fx_t             quo_reg;
    fx_t             quo_next;

    logic [FX_W-1:0] nabs;
    logic [FX_W-1:0] dabs;

    // magnitudes of the operands
    always_comb
    begin
        nabs = num.val[FX_W-1] ? FX_W'(-num.val) : FX_W'(num.val);
        dabs = den.val[FX_W-1] ? FX_W'(-den.val) : FX_W'(den.val);
    end

    // setup stage
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            rem_reg[0]  <= '0;
            nq_reg[0]   <= {nabs, {FRAC_BITS{1'b0}}};
            dabs_reg[0] <= dabs;
            neg_reg[0]  <= num.val[FX_W-1] ^ den.val[FX_W-1];
            zero_reg[0] <= (den.val == '0);
            pos_reg[0]  <= ~num.val[FX_W-1];
            flag_reg[0] <= num.flag | den.flag;
        end
    end

    // one quotient bit per stage
    for (genvar i = 0; i < QB; i++)
    begin : g_step
        logic [FX_W:0]   r2;
        logic            ge;
        logic [FX_W-1:0] rem_next;
        logic [QB-1:0]   nq_next;

        always_comb
        begin
            r2       = {rem_reg[i], nq_reg[i][QB-1]};
            ge       = (r2 >= {1'b0, dabs_reg[i]});
            rem_next = ge ? FX_W'(r2 - {1'b0, dabs_reg[i]}) : r2[FX_W-1:0];
            nq_next  = {nq_reg[i][QB-2:0], ge};
        end

        always_ff @(posedge clk)
        begin
            if (en)
            begin
                rem_reg[i+1]  <= rem_next;
                nq_reg[i+1]   <= nq_next;
                dabs_reg[i+1] <= dabs_reg[i];
                neg_reg[i+1]  <= neg_reg[i];
                zero_reg[i+1] <= zero_reg[i];
                pos_reg[i+1]  <= pos_reg[i];
                flag_reg[i+1] <= flag_reg[i];
            end
        end
    end

    // sign, saturation and zero divisor
    always_comb
    begin
        logic signed [63:0] mag;
        mag = $signed({{(64-QB){1'b0}}, nq_reg[QB]});
        if (zero_reg[QB])
        begin
            quo_next = fx_sat(pos_reg[QB] ? 64'sh7FFF_FFFF_FFFF_FFFF
                                          : 64'sh8000_0000_0000_0000, SAT_W);
            quo_next.flag = 1'b1;
        end
        else
        begin
            quo_next = fx_sat(neg_reg[QB] ? -mag : mag, SAT_W);
            quo_next.flag = quo_next.flag | flag_reg[QB];
        end
    end

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            quo_reg <= quo_next;
        end
    end

    assign quo = quo_reg;

endmodule

// ----- src/aliev_panfilov_reaction_rate.sv -----
// Aliev-Panfilov reaction rates, top level: input stage, datapath schedule, output
// depends on aprr_pkg, aprr_fmul, aprr_div, aprr_delay
//
// usage
// - s_axis carries one mesh point per request: tdata holds u, v and the stimulus
//   current (Q8.24, lowest first), tlast marks the end of a sweep
// - m_axis returns rate_u and rate_v in tdata, the saturation flag in tuser and
//   the copied last marker in tlast
// - constants k, a, mu1, mu2 and eps are written through cfg_wen / cfg_index /
//   cfg_data while no point is in flight
// throughput and latency
// - one point per cycle unless stalled; every stage is a register and the whole
//   pipeline advances together
// - the result path is set by the pipelined divider (58 stages: setup, one per
//   quotient bit, output) followed by a multiply, an add and a multiply
// reset and stall
// - reset clears the constants and all valid bits; no clearing pass is needed
// - when m_axis_tready is low with a result waiting, the pipeline freezes and
//   s_axis_tready drops; nothing is lost or repeated
module aliev_panfilov_reaction_rate
    import aprr_pkg::*;
#(
    parameter int DATA_WIDTH = 32
) (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    // [31:0] potential_u, [63:32] recovery_v, [95:64] stim_current
    input  logic [95:0] s_axis_tdata,
    input  logic        s_axis_tlast,
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // [31:0] rate_u, [63:32] rate_v
    output logic [63:0] m_axis_tdata,
    // [0] saturated
    output logic        m_axis_tuser,
    output logic        m_axis_tlast,
    input  logic        cfg_wen,
    input  logic [2:0]  cfg_index,
    input  logic [31:0] cfg_data
);

    localparam int SAT_W = (DATA_WIDTH > 32) ? 32 : ((DATA_WIDTH < 16) ? 16 : DATA_WIDTH);
    localparam int LAT   = 64;
    localparam int FXB   = $bits(fx_t);

    logic en;

    // configuration registers
    logic signed [31:0] k_reg, a_reg, mu1_reg, mu2_reg, eps_reg;
    fx_t                c_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            k_reg   <= '0;
            a_reg   <= '0;
            mu1_reg <= '0;
            mu2_reg <= '0;
            eps_reg <= '0;
            c_reg   <= '0;
        end
        else
        begin
            if (cfg_wen)
            begin
                case (cfg_index)
                    REG_GAIN_K:   k_reg   <= cfg_data;
                    REG_THRESH_A: a_reg   <= cfg_data;
                    REG_MU1:      mu1_reg <= cfg_data;
                    REG_MU2:      mu2_reg <= cfg_data;
                    REG_EPS:      eps_reg <= cfg_data;
                    default:      ;
                endcase
            end
            // -(1+a), registered from a_reg in the cycle after it
            c_reg <= fx_sat(FX_NEG_ONE - 64'(a_reg), SAT_W);
        end
    end

    // pipeline enable and valid line
    logic [LAT:0] vld_reg;

    assign en            = ~vld_reg[LAT] | m_axis_tready;
    assign s_axis_tready = en;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg <= '0;
        end
        else if (en)
        begin
            vld_reg <= {vld_reg[LAT-1:0], s_axis_tvalid};
        end
    end

    // input stage
    fx_t  u0_reg, v0_reg, st0_reg;
    logic last0_reg;

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            u0_reg    <= fx_raw(s_axis_tdata[31:0]);
            v0_reg    <= fx_raw(s_axis_tdata[63:32]);
            st0_reg   <= fx_raw(s_axis_tdata[95:64]);
            last0_reg <= s_axis_tlast;
        end
    end

    fx_t k_fx, a_fx, mu1_fx, mu2_fx, eps_fx;
    assign k_fx   = fx_raw(k_reg);
    assign a_fx   = fx_raw(a_reg);
    assign mu1_fx = fx_raw(mu1_reg);
    assign mu2_fx = fx_raw(mu2_reg);
    assign eps_fx = fx_raw(eps_reg);

    // first products, ready at T2
    fx_t uu2, au2, uv2;
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_uu (.clk(clk), .en(en), .a(u0_reg), .b(u0_reg), .y(uu2));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_au (.clk(clk), .en(en), .a(a_fx),   .b(u0_reg), .y(au2));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_uv (.clk(clk), .en(en), .a(u0_reg), .b(v0_reg), .y(uv2));

    // sums with u at T1
    fx_t d1_reg, s1_reg;
    always_ff @(posedge clk)
    begin
        if (en)
        begin
            d1_reg <= fx_add(mu2_fx, u0_reg, SAT_W);
            s1_reg <= fx_add(c_reg, u0_reg, SAT_W);
        end
    end

    // aligned copies of inputs
    fx_t u2, u3, v1, v5, st8;
    aprr_delay #(.W(FXB), .N(2)) u_dly_u2 (.clk(clk), .en(en), .din(u0_reg),  .dout(u2));
    aprr_delay #(.W(FXB), .N(3)) u_dly_u3 (.clk(clk), .en(en), .din(u0_reg),  .dout(u3));
    aprr_delay #(.W(FXB), .N(1)) u_dly_v1 (.clk(clk), .en(en), .din(v0_reg),  .dout(v1));
    aprr_delay #(.W(FXB), .N(5)) u_dly_v5 (.clk(clk), .en(en), .din(v0_reg),  .dout(v5));
    aprr_delay #(.W(FXB), .N(8)) u_dly_s8 (.clk(clk), .en(en), .din(st0_reg), .dout(st8));

    // cubic of the rate of u
    fx_t uuu4, cuu4, au4, uuu5, t5_reg, t6_reg, t8, uv9, t9_reg, r10_reg, r11_reg;
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_uuu (.clk(clk), .en(en), .a(uu2),   .b(u2),  .y(uuu4));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_cuu (.clk(clk), .en(en), .a(c_reg), .b(uu2), .y(cuu4));
    aprr_delay #(.W(FXB), .N(2)) u_dly_au (.clk(clk), .en(en), .din(au2),  .dout(au4));
    aprr_delay #(.W(FXB), .N(1)) u_dly_uuu (.clk(clk), .en(en), .din(uuu4), .dout(uuu5));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_kt (.clk(clk), .en(en), .a(k_fx), .b(t6_reg), .y(t8));
    aprr_delay #(.W(FXB), .N(7)) u_dly_uv (.clk(clk), .en(en), .din(uv2), .dout(uv9));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            t5_reg  <= fx_add(cuu4, au4, SAT_W);
            t6_reg  <= fx_add(uuu5, t5_reg, SAT_W);
            t9_reg  <= fx_add(t8, st8, SAT_W);
            r10_reg <= fx_add(uv9, t9_reg, SAT_W);
            r11_reg <= fx_neg(r10_reg, SAT_W);
        end
    end

    // recovery factor of the rate of v
    fx_t s3, s5, s6_reg, s7_reg;
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_ks (.clk(clk), .en(en), .a(k_fx), .b(s1_reg), .y(s3));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_us (.clk(clk), .en(en), .a(u3),   .b(s3),     .y(s5));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            s6_reg <= fx_add(s5, v5, SAT_W);
            s7_reg <= fx_neg(s6_reg, SAT_W);
        end
    end

    // quotient branch: v / (mu2 + u), then eps + mu1 * q
    fx_t q59, q61, q62_reg, s62, ru64, rv64;
    aprr_div #(.SAT_W(SAT_W)) u_div (.clk(clk), .en(en), .num(v1), .den(d1_reg), .quo(q59));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_mq (.clk(clk), .en(en), .a(mu1_fx), .b(q59), .y(q61));

    always_ff @(posedge clk)
    begin
        if (en)
        begin
            q62_reg <= fx_add(eps_fx, q61, SAT_W);
        end
    end

    aprr_delay #(.W(FXB), .N(55)) u_dly_s (.clk(clk), .en(en), .din(s7_reg), .dout(s62));
    aprr_fmul #(.SAT_W(SAT_W)) u_mul_rv (.clk(clk), .en(en), .a(s62), .b(q62_reg), .y(rv64));
    aprr_delay #(.W(FXB), .N(53)) u_dly_ru (.clk(clk), .en(en), .din(r11_reg), .dout(ru64));

    // last marker follows the whole schedule
    logic last64;
    aprr_delay #(.W(1), .N(LAT)) u_dly_last (.clk(clk), .en(en), .din(last0_reg), .dout(last64));

    // output stage
    assign m_axis_tvalid = vld_reg[LAT];
    assign m_axis_tdata  = {rv64.val, ru64.val};
    assign m_axis_tuser  = ru64.flag | rv64.flag;
    assign m_axis_tlast  = last64;

`ifndef ASSERT_OFF
    // results stay inside the saturation range
    a_ru_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((ru64.val >>> (SAT_W - 1)) == 32'sd0 ||
                           (ru64.val >>> (SAT_W - 1)) == -32'sd1))
        else $error("rate_u outside saturation range");

    a_rv_range: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> ((rv64.val >>> (SAT_W - 1)) == 32'sd0 ||
                           (rv64.val >>> (SAT_W - 1)) == -32'sd1))
        else $error("rate_v outside saturation range");

    // a frozen pipeline keeps its valid bits
    a_freeze: assert property (@(posedge clk) disable iff (!rst_n)
        !s_axis_tready |=> $stable(vld_reg))
        else $error("valid line moved during stall");

    // a zero divisor always reports saturation
    a_zero_div: assert property (@(posedge clk) disable iff (!rst_n)
        (en && u_div.zero_reg[u_div.QB]) |=> q59.flag)
        else $error("zero divisor without flag");
`endif

endmodule
